@@ design/bfds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box filter downscaler package
// Shared types, widths, register codes and the reciprocal table for the
// block average.
// ----------------------------------------------------------------------------
package bfds_pkg;

  localparam int unsigned MaxWidth   = 4096;
  localparam int unsigned MaxScale   = 8;
  localparam int unsigned CoordW     = 12;
  localparam int unsigned DimW       = 13;
  localparam int unsigned KW         = 4;
  localparam int unsigned SubW       = 3;
  localparam int unsigned RunW       = 11;
  localparam int unsigned SumW       = 14;
  localparam int unsigned RecipShift = 21;
  localparam int unsigned RecipW     = 22;
  localparam int unsigned ProdW      = SumW + RecipW;
  localparam int unsigned MemW       = 3 * SumW;

  localparam logic [DimW-1:0] WidthReset  = 13'd1920;
  localparam logic [DimW-1:0] HeightReset = 13'd1080;
  localparam logic [KW-1:0]   ScaleReset  = 4'd2;
  localparam logic [DimW-1:0] DimMax      = 13'd4096;
  localparam logic [KW-1:0]   ScaleMax    = 4'd8;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SCALE_FACTOR = 2'd2;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic       frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       row_end;
    logic       frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic       accept;
    logic       mem_rd;
    logic       mem_wr;
    logic       div_en;
    logic [1:0] div_sel;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic start_work;
    logic emit;
    logic out_free;
  } sts_t;

  // ceil(2^21 / (k*k)), exact floor quotient for sums below 2^14
  function automatic logic [RecipW-1:0] recip_f(input logic [KW-1:0] k);
    logic [RecipW-1:0] r;
    case (k)
      4'd1:    r = 22'd2097152;
      4'd2:    r = 22'd524288;
      4'd3:    r = 22'd233017;
      4'd4:    r = 22'd131072;
      4'd5:    r = 22'd83887;
      4'd6:    r = 22'd58255;
      4'd7:    r = 22'd42800;
      4'd8:    r = 22'd32768;
      default: r = 22'd2097152;
    endcase
    return r;
  endfunction

endpackage

@@ design/bfds_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box filter downscaler controller
// Sequences item intake, accumulator read-modify-write, the shared divide
// multiplier and the result load.
// ----------------------------------------------------------------------------
module bfds_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bfds_pkg::sts_t sts_i,
  output bfds_pkg::cmd_t cmd_o
);
  import bfds_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_WR   = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.start_work) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_WR;
      end
      ST_WR: begin
        cmd_o.mem_wr = 1'b1;
        cnt_d        = CH_RED;
        state_d      = sts_i.emit ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_en  = 1'b1;
        cmd_o.div_sel = cnt_q;
        if (cnt_q == CH_BLUE) begin
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= CH_RED;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ design/bfds_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box filter downscaler datapath
// Configuration, position counters, running block sums, column accumulator
// RAM, reciprocal multiplier and the result register.
// ----------------------------------------------------------------------------
module bfds_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [12:0]           cfg_data_i,
  input  bfds_pkg::pixel_in_t   in_data_i,
  input  bfds_pkg::cmd_t        cmd_i,
  output bfds_pkg::sts_t        sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bfds_pkg::pixel_out_t  out_data_o
);
  import bfds_pkg::*;

  logic [DimW-1:0]   width_q, height_q;
  logic [KW-1:0]     scale_q;
  logic [DimW-1:0]   w_eff, h_eff;
  logic [KW-1:0]     k_eff;
  logic              cfg_clear;

  logic [CoordW-1:0] col_q, row_q, bc_q;
  logic [SubW-1:0]   rib_q, cib_q;
  logic [RunW-1:0]   run_q [3];
  logic              col_ok_q, row_ok_q;

  logic [CoordW-1:0] cur_col, cur_row, cur_bc;
  logic [SubW-1:0]   cur_rib, cur_cib;
  logic [RunW-1:0]   cur_run [3];
  logic [RunW-1:0]   add_run [3];
  logic [7:0]        px [3];

  logic [CoordW-1:0] col_d, row_d, bc_d;
  logic [SubW-1:0]   rib_d, cib_d;
  logic [RunW-1:0]   run_d [3];

  logic in_col, in_row, blk_end, band_end, last_col, last_band, row_wrap, frame_wrap;

  logic [RunW-1:0]   sum_q [3];
  logic [CoordW-1:0] bc_work_q;
  logic              first_q, emit_q, row_end_q, frame_end_q;

  logic [MemW-1:0]   mem [MaxWidth];
  logic [MemW-1:0]   rd_q;
  logic [MemW-1:0]   new_sum;
  logic [SumW-1:0]   acc_q [3];
  logic [SumW-1:0]   acc_sel;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [7:0]        q_red_q, q_green_q;

  logic              out_valid_q;
  pixel_out_t        out_data_q;

  // register clamp
  always_comb begin
    w_eff = (width_q == '0) ? 13'd1 : ((width_q > DimMax) ? DimMax : width_q);
    h_eff = (height_q == '0) ? 13'd1 : ((height_q > DimMax) ? DimMax : height_q);
    k_eff = (scale_q == '0) ? 4'd1 : ((scale_q > ScaleMax) ? ScaleMax : scale_q);
  end

  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_SCALE_FACTOR: cfg_clear = 1'b1;
        default: cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      scale_q  <= ScaleReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        CFG_SCALE_FACTOR: scale_q  <= cfg_data_i[KW-1:0];
        default: ;
      endcase
    end
  end

  // position update for one item
  always_comb begin
    px[0] = in_data_i.red_in;
    px[1] = in_data_i.green_in;
    px[2] = in_data_i.blue_in;
    cur_col = in_data_i.frame_start ? '0 : col_q;
    cur_row = in_data_i.frame_start ? '0 : row_q;
    cur_bc  = in_data_i.frame_start ? '0 : bc_q;
    cur_rib = in_data_i.frame_start ? '0 : rib_q;
    cur_cib = in_data_i.frame_start ? '0 : cib_q;
    for (int c = 0; c < 3; c++) begin
      cur_run[c] = in_data_i.frame_start ? '0 : run_q[c];
      add_run[c] = cur_run[c] + {3'b0, px[c]};
    end

    in_col = (cur_cib == '0) ? (({1'b0, cur_col} + {9'b0, k_eff}) <= w_eff) : col_ok_q;
    in_row = (cur_rib == '0) ? (({1'b0, cur_row} + {9'b0, k_eff}) <= h_eff) : row_ok_q;
    blk_end    = ({1'b0, cur_cib} + 4'd1) >= k_eff;
    band_end   = ({1'b0, cur_rib} + 4'd1) >= k_eff;
    last_col   = ({1'b0, cur_col} + 13'd1 + {9'b0, k_eff}) > w_eff;
    last_band  = ({1'b0, cur_row} + 13'd1 + {9'b0, k_eff}) > h_eff;
    row_wrap   = ({1'b0, cur_col} + 13'd1) >= w_eff;
    frame_wrap = ({1'b0, cur_row} + 13'd1) >= h_eff;

    col_d = cur_col + 12'd1;
    row_d = cur_row;
    rib_d = cur_rib;
    bc_d  = cur_bc;
    cib_d = cur_cib;
    for (int c = 0; c < 3; c++) begin
      run_d[c] = cur_run[c];
    end
    if (in_col && in_row) begin
      if (blk_end) begin
        cib_d = '0;
        bc_d  = cur_bc + 12'd1;
        for (int c = 0; c < 3; c++) begin
          run_d[c] = '0;
        end
      end else begin
        cib_d = cur_cib + 3'd1;
        for (int c = 0; c < 3; c++) begin
          run_d[c] = add_run[c];
        end
      end
    end
    if (row_wrap) begin
      col_d = '0;
      bc_d  = '0;
      cib_d = '0;
      for (int c = 0; c < 3; c++) begin
        run_d[c] = '0;
      end
      row_d = cur_row + 12'd1;
      rib_d = band_end ? '0 : cur_rib + 3'd1;
      if (frame_wrap) begin
        row_d = '0;
        rib_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      bc_q     <= '0;
      rib_q    <= '0;
      cib_q    <= '0;
      col_ok_q <= 1'b0;
      row_ok_q <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        run_q[c] <= '0;
      end
    end else if (cfg_clear) begin
      col_q <= '0;
      row_q <= '0;
      bc_q  <= '0;
      rib_q <= '0;
      cib_q <= '0;
      for (int c = 0; c < 3; c++) begin
        run_q[c] <= '0;
      end
    end else if (cmd_i.accept) begin
      col_q    <= col_d;
      row_q    <= row_d;
      bc_q     <= bc_d;
      rib_q    <= rib_d;
      cib_q    <= cib_d;
      col_ok_q <= in_col;
      row_ok_q <= in_row;
      for (int c = 0; c < 3; c++) begin
        run_q[c] <= run_d[c];
      end
    end
  end

  // latch block-row work
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && sts_o.start_work) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= add_run[c];
      end
      bc_work_q   <= cur_bc;
      first_q     <= (cur_rib == '0);
      emit_q      <= band_end;
      row_end_q   <= last_col;
      frame_end_q <= last_col && last_band;
    end
  end

  // column accumulator RAM
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      new_sum[c*SumW +: SumW] = first_q ? {3'b0, sum_q[c]}
                                        : rd_q[c*SumW +: SumW] + {3'b0, sum_q[c]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rd_q <= mem[bc_work_q];
    end
    if (cmd_i.mem_wr) begin
      mem[bc_work_q] <= new_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= new_sum[c*SumW +: SumW];
      end
    end
  end

  // average by reciprocal multiply, one channel a cycle
  always_comb begin
    case (cmd_i.div_sel)
      CH_RED:   acc_sel = acc_q[0];
      CH_GREEN: acc_sel = acc_q[1];
      default:  acc_sel = acc_q[2];
    endcase
    prod_d = acc_sel * recip_f(k_eff);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_en) begin
      prod_q <= prod_d;
      case (cmd_i.div_sel)
        CH_GREEN: q_red_q   <= prod_q[RecipShift +: 8];
        CH_BLUE:  q_green_q <= prod_q[RecipShift +: 8];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q.red_out   <= q_red_q;
      out_data_q.green_out <= q_green_q;
      out_data_q.blue_out  <= prod_q[RecipShift +: 8];
      out_data_q.row_end   <= row_end_q;
      out_data_q.frame_end <= frame_end_q;
    end
  end

  assign sts_o.start_work = in_col && in_row && blk_end;
  assign sts_o.emit       = emit_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_data_q;

endmodule

@@ design/box_filter_image_downscaler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box filter image downscaler
// Averages each k-by-k block of raster pixels into one RGB output pixel.
// ----------------------------------------------------------------------------
// Intake: an item inside a block row is taken with no stall; an item that
// closes a block row stalls intake for an accumulator RAM read then write;
// one that closes a full block also stalls for 3 reciprocal-multiply steps
// and the result load, which waits until the output register is free.
// Reset: counters and running sums cleared, registers 1920x1080 with k=2;
// the accumulator RAM is not cleared (written at each band's first row).
module box_filter_image_downscaler_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [12:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bfds_pkg::pixel_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bfds_pkg::pixel_out_t out_data_o
);
  import bfds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  bfds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bfds_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_work_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && sts.start_work) |=> in_stall_o)
    else $error("intake not held during accumulator update");

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_wr |-> $past(cmd.mem_rd))
    else $error("accumulator write without preceding read");

  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.frame_end || out_data_o.row_end))
    else $error("frame end without row end");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a stalled item");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box filter image downscaler testbench
// Streams raster pixels through the downscaler over many frame sizes and
// block factors, predicts every block average with a behavioral model of
// the accumulator line, and checks each output item in order, under random
// gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
  import bfds_pkg::*;

  localparam logic [1:0] CfgUnused     = 2'd3;
  localparam int         RandomItems   = 1950;
  localparam int         SettleCycles  = 16;
  localparam int         IdlePercent   = 11;

  class box_avg_scoreboard;
    logic [DimW-1:0] width_q;
    logic [DimW-1:0] height_q;
    logic [KW-1:0]   scale_q;
    int unsigned     col_sum [MaxWidth][3];
    int unsigned     pix_col, pix_row, band_row, blk_sub, blk_col;
    int unsigned     run_sum [3];
    pixel_out_t      pending_pixels [$];
    int              errors;

    function new();
      width_q  = WidthReset;
      height_q = HeightReset;
      scale_q  = ScaleReset;
      errors   = 0;
      clear_position();
    endfunction

    function void clear_position();
      pix_col  = 0;
      pix_row  = 0;
      band_row = 0;
      blk_sub  = 0;
      blk_col  = 0;
      for (int c = 0; c < 3; c++) run_sum[c] = 0;
    endfunction

    function int unsigned frame_w();
      return (width_q == 0) ? 1 : (width_q > DimMax) ? DimMax : width_q;
    endfunction

    function int unsigned frame_h();
      return (height_q == 0) ? 1 : (height_q > DimMax) ? DimMax : height_q;
    endfunction

    function int unsigned block_k();
      return (scale_q == 0) ? 1 : (scale_q > ScaleMax) ? ScaleMax : scale_q;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DimW-1:0] val);
      case (idx)
        CFG_FRAME_WIDTH: begin
          width_q = val;
          clear_position();
        end
        CFG_FRAME_HEIGHT: begin
          height_q = val;
          clear_position();
        end
        CFG_SCALE_FACTOR: begin
          scale_q = val[KW-1:0];
          clear_position();
        end
        default: ;
      endcase
    endfunction

    function void note_pixel(pixel_in_t p);
      int unsigned w, h, k, blocks_x, used_w, used_h, bc, area;
      int unsigned px [3];
      pixel_out_t  e;
      w = frame_w();
      h = frame_h();
      k = block_k();
      blocks_x = w / k;
      used_w = blocks_x * k;
      used_h = (h / k) * k;
      px[CH_RED]   = p.red_in;
      px[CH_GREEN] = p.green_in;
      px[CH_BLUE]  = p.blue_in;
      if (p.frame_start) clear_position();
      if (pix_col < used_w && pix_row < used_h) begin
        for (int c = 0; c < 3; c++) run_sum[c] += px[c];
        if (blk_sub + 1 >= k) begin
          bc = blk_col % MaxWidth;
          for (int c = 0; c < 3; c++) begin
            if (band_row == 0) col_sum[bc][c] = run_sum[c];
            else col_sum[bc][c] += run_sum[c];
          end
          if (band_row + 1 >= k) begin
            area = k * k;
            e.red_out   = 8'(col_sum[bc][CH_RED] / area);
            e.green_out = 8'(col_sum[bc][CH_GREEN] / area);
            e.blue_out  = 8'(col_sum[bc][CH_BLUE] / area);
            e.row_end   = (blk_col + 1 >= blocks_x);
            e.frame_end = e.row_end && (pix_row + 1 >= used_h);
            pending_pixels.push_back(e);
          end
          for (int c = 0; c < 3; c++) run_sum[c] = 0;
          blk_sub = 0;
          blk_col++;
        end else begin
          blk_sub++;
        end
      end
      pix_col++;
      if (pix_col >= w) begin
        pix_col = 0;
        blk_col = 0;
        blk_sub = 0;
        for (int c = 0; c < 3; c++) run_sum[c] = 0;
        pix_row++;
        band_row++;
        if (band_row >= k) band_row = 0;
        if (pix_row >= h) begin
          pix_row  = 0;
          band_row = 0;
        end
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_pixel(pixel_out_t r);
      pixel_out_t e;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual %h", $time, r);
      end else begin
        e = pending_pixels.pop_front();
        compare_field("red_out", e.red_out, r.red_out);
        compare_field("green_out", e.green_out, r.green_out);
        compare_field("blue_out", e.blue_out, r.blue_out);
        compare_field("row_end", e.row_end, r.row_end);
        compare_field("frame_end", e.frame_end, r.frame_end);
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i;
  logic [DimW-1:0] cfg_data_i;
  logic            in_valid_i;
  logic            in_stall_o;
  pixel_in_t       in_data_i;
  logic            out_valid_o;
  logic            out_stall_i;
  pixel_out_t      out_data_o;

  box_avg_scoreboard sb;
  int                sent_items;
  logic              calm;

  box_filter_image_downscaler_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  assign calm = (sent_items >= 700) && (sent_items < 1050);

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IdlePercent);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_pixel(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_pixel(out_data_o);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [DimW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(input pixel_in_t p);
    while (!calm && $urandom_range(0, 99) < IdlePercent) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_items++;
  endtask

  // drop valid, then hold until every expected item is out
  task automatic drain(input int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic send_random(input int n, input logic first_start);
    pixel_in_t p;
    for (int i = 0; i < n; i++) begin
      p = pixel_in_t'($urandom);
      p.frame_start = (i == 0) && first_start;
      send_pixel(p);
    end
  endtask

  task automatic run_phase(input int phase_no);
    logic [1:0]      regs [3];
    logic [DimW-1:0] vals [3];
    int              start, idx, r, nframes, npix, stray;
    logic            lead_start;
    pixel_in_t       p;
    regs = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_SCALE_FACTOR};
    r = $urandom_range(0, 9);
    vals[0] = DimW'((r < 8) ? $urandom_range(1, 16) : $urandom_range(17, 64));
    vals[1] = DimW'($urandom_range(1, 16));
    r = $urandom_range(0, 9);
    vals[2] = DimW'((r < 8) ? $urandom_range(1, 8) : (r == 8) ? 0 : $urandom_range(9, 15));
    start = $urandom_range(0, 2);
    for (int j = 0; j < 3; j++) begin
      idx = (start + j) % 3;
      if (j == 0 || $urandom_range(0, 9) < 7) write_reg(regs[idx], vals[idx]);
    end
    nframes = $urandom_range(1, 3);
    for (int f = 0; f < nframes && sent_items < RandomItems; f++) begin
      npix = sb.frame_w() * sb.frame_h();
      r = $urandom_range(0, 9);
      stray = -1;
      if (r == 0 && npix > 1) npix = $urandom_range(1, npix - 1);
      if (r == 1 && npix > 1) stray = $urandom_range(1, npix - 1);
      lead_start = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < npix && sent_items < RandomItems; i++) begin
        if (phase_no == 2 && f == 0 && i == npix / 2) drain(0);
        p = pixel_in_t'($urandom);
        p.frame_start = (i == 0) ? lead_start : (i == stray);
        send_pixel(p);
      end
    end
    drain(SettleCycles);
  endtask

  initial begin
    sb          = new();
    sent_items  = 0;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FRAME_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // k of one on the reset frame size: every pixel is its own block
    write_reg(CFG_SCALE_FACTOR, 13'd0);
    send_pixel('{blue_in: 8'h00, green_in: 8'h00, red_in: 8'h00, frame_start: 1'b1});
    send_pixel('{blue_in: 8'hff, green_in: 8'hff, red_in: 8'hff, frame_start: 1'b0});
    send_random(1, 1'b0);
    drain(SettleCycles);

    // saturated registers, block taller than the frame: nothing comes out
    write_reg(CFG_FRAME_WIDTH, 13'h1fff);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    write_reg(CFG_SCALE_FACTOR, 13'h1fff);
    send_random(3, 1'b1);
    drain(SettleCycles);

    // one-pixel rows: every item closes an output row
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'h1fff);
    write_reg(CFG_SCALE_FACTOR, 13'd1);
    send_random(3, 1'b1);
    drain(SettleCycles);

    // single full block, and a write to the unused index
    write_reg(CFG_FRAME_WIDTH, 13'd2);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    write_reg(CFG_SCALE_FACTOR, 13'd2);
    write_reg(CfgUnused, 13'($urandom));
    for (int i = 0; i < 4; i++)
      send_pixel('{blue_in: 8'hff, green_in: 8'hff, red_in: 8'hff, frame_start: i == 0});
    drain(SettleCycles);

    // partial blocks on the right and bottom edges
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    send_random(9, 1'b1);
    drain(SettleCycles);

    for (int ph = 0; sent_items < RandomItems; ph++) run_phase(ph);

    drain(SettleCycles);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
